// ----- rtl/krfs_pkg.sv -----
// Package for the keyed record field store: sizes, codes, FSM states
// and byte-mask helpers. Depends on nothing; used by the top level.
package krfs_pkg;

  // Table geometry
  localparam int unsigned RECORD_SLOTS      = 32;
  localparam int unsigned FIELDS_PER_RECORD = 8;
  localparam int unsigned FIELD_BYTES_MAX   = 8;

  localparam int unsigned SLOT_W     = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int unsigned SLOT_CNT_W = $clog2(RECORD_SLOTS + 1);
  localparam int unsigned FIELD_W    = (FIELDS_PER_RECORD > 1) ? $clog2(FIELDS_PER_RECORD) : 1;
  localparam int unsigned LEN_W      = 4;   // stored length 0..8
  localparam int unsigned ROW_W      = FIELDS_PER_RECORD * LEN_W;
  localparam int unsigned KEY_W      = 128;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned BYTES_AW   = SLOT_W + FIELD_W;
  localparam int unsigned BYTES_DEPTH = 2 ** BYTES_AW;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_DELETE = 2'd2
  } krfs_kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_NOT_STORED = 2'd2,
    ST_FULL       = 2'd3
  } krfs_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LEN,
    S_BYTES,
    S_FINISH
  } krfs_state_t;

  // Mask that keeps the lowest n bytes of a 64-bit word
  function automatic logic [DATA_W-1:0] low_bytes_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (LEN_W'(b) < n) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // Write length clipped to eight bytes
  function automatic logic [LEN_W-1:0] clip_len(input logic [7:0] count);
    logic [LEN_W-1:0] k;
    k = (count >= 8'(FIELD_BYTES_MAX)) ? LEN_W'(FIELD_BYTES_MAX) : count[LEN_W-1:0];
    return k;
  endfunction

endpackage

// ----- rtl/krfs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the key, length and field byte stores.
module krfs_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/keyed_record_field_store.sv -----
// Keyed record field store: top level with request sequencer and stores.
// Depends on krfs_pkg and krfs_ram.
//
// A fully associative table of RECORD_SLOTS records keyed by a 128-bit hash,
// each with FIELDS_PER_RECORD fields of up to 8 bytes. One request at a time:
// a read, write or delete walks the key memory one slot per cycle (stopping at
// the first match); a read or write then reads or updates the field length row
// and the field byte word, and a delete clears the slot's valid bit. Kind 3,
// zero-length writes and out-of-range fields on a read or write skip the walk
// and go straight to the finish state. The input is taken again in the cycle
// after the result is loaded into the output register.
// Valid bits live in flip-flops and clear at reset, so no clearing pass is
// needed. The result sits in an output register, so the next request is taken
// while a result waits for transfer.
module keyed_record_field_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_key_high,
  input  logic [63:0] in_key_low,
  input  logic [7:0]  in_field_index,
  input  logic [63:0] in_write_data,
  input  logic [7:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_data,
  output logic [3:0]  out_read_length
);
  import krfs_pkg::*;

  // Control state
  krfs_state_t             state_r, state_nxt;
  logic [SLOT_CNT_W-1:0]   issue_cnt_r, issue_cnt_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]       free_idx_r, free_idx_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic                    alloc_r, alloc_nxt;
  logic [RECORD_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Request and result payload
  logic [1:0]        req_kind_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [7:0]        req_fidx_r;
  logic [DATA_W-1:0] req_wdata_r;
  logic [7:0]        req_count_r;
  logic [LEN_W-1:0]  stored_r, stored_nxt;
  krfs_status_t      res_status_r, res_status_nxt;
  logic [DATA_W-1:0] res_rdata_r, res_rdata_nxt;
  logic [LEN_W-1:0]  res_rlen_r, res_rlen_nxt;
  logic [1:0]        out_status_r;
  logic [DATA_W-1:0] out_read_data_r;
  logic [LEN_W-1:0]  out_read_length_r;
  logic              out_load;

  // Memory ports
  logic               key_re, key_we;
  logic [SLOT_W-1:0]  key_raddr;
  logic [KEY_W-1:0]   key_rdata;
  logic               len_re, len_we;
  logic [SLOT_W-1:0]  len_raddr;
  logic [ROW_W-1:0]   len_rdata, len_wrow;
  logic               bytes_re, bytes_we;
  logic [BYTES_AW-1:0] bytes_addr;
  logic [DATA_W-1:0]  bytes_rdata, bytes_wdata;

  // Scan helpers
  logic              accept;
  logic              hit, last, free_here;
  logic [FIELD_W-1:0] fsel;
  logic [LEN_W-1:0]  stored_len, keep_len, rlen;

  assign accept    = in_valid && in_ready;
  assign fsel      = req_fidx_r[FIELD_W-1:0];
  assign hit       = cmp_vld_r && slot_valid_r[cmp_idx_r] && (key_rdata == req_key_r);
  assign last      = cmp_vld_r && (cmp_idx_r == SLOT_W'(RECORD_SLOTS - 1));
  assign free_here = cmp_vld_r && !slot_valid_r[cmp_idx_r];
  assign stored_len = len_rdata[fsel*LEN_W +: LEN_W];
  assign keep_len   = clip_len(req_count_r);
  assign rlen       = (req_count_r < 8'(stored_r)) ? req_count_r[LEN_W-1:0] : stored_r;
  assign bytes_addr = {slot_r, fsel};
  assign key_raddr  = issue_cnt_r[SLOT_W-1:0];

  krfs_ram #(.DEPTH(RECORD_SLOTS), .WIDTH(KEY_W)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(slot_r), .wdata(req_key_r),
    .re(key_re), .raddr(key_raddr), .rdata(key_rdata)
  );

  krfs_ram #(.DEPTH(RECORD_SLOTS), .WIDTH(ROW_W)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(slot_r), .wdata(len_wrow),
    .re(len_re), .raddr(len_raddr), .rdata(len_rdata)
  );

  krfs_ram #(.DEPTH(BYTES_DEPTH), .WIDTH(DATA_W)) u_bytes_ram (
    .clk(clk), .we(bytes_we), .waddr(bytes_addr), .wdata(bytes_wdata),
    .re(bytes_re), .raddr(bytes_addr), .rdata(bytes_rdata)
  );

  // Sequencer: next state, memory controls and result
  always_comb begin
    state_nxt      = state_r;
    issue_cnt_nxt  = issue_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    slot_nxt       = slot_r;
    alloc_nxt      = alloc_r;
    slot_valid_nxt = slot_valid_r;
    stored_nxt     = stored_r;
    res_status_nxt = res_status_r;
    res_rdata_nxt  = res_rdata_r;
    res_rlen_nxt   = res_rlen_r;
    out_valid_nxt  = out_valid_r;
    out_load       = 1'b0;
    key_re         = 1'b0;
    key_we         = 1'b0;
    len_re         = 1'b0;
    len_we         = 1'b0;
    len_raddr      = slot_r;
    len_wrow       = '0;
    bytes_re       = 1'b0;
    bytes_we       = 1'b0;
    bytes_wdata    = req_wdata_r & low_bytes_mask(keep_len);
    in_ready       = (state_r == S_IDLE);

    // Result register drains on transfer
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          issue_cnt_nxt  = '0;
          free_found_nxt = 1'b0;
          res_rdata_nxt  = '0;
          res_rlen_nxt   = '0;
          case (in_kind)
            KIND_READ: begin
              if (in_field_index >= 8'(FIELDS_PER_RECORD)) begin
                res_status_nxt = ST_NOT_STORED;
                state_nxt      = S_FINISH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_WRITE: begin
              if (in_byte_count == 8'd0 || in_field_index >= 8'(FIELDS_PER_RECORD)) begin
                res_status_nxt = ST_INVALID;
                state_nxt      = S_FINISH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_DELETE: state_nxt = S_SCAN;
            default: begin
              res_status_nxt = ST_INVALID;
              state_nxt      = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next key read while comparing the previous one
        if (issue_cnt_r < SLOT_CNT_W'(RECORD_SLOTS)) begin
          key_re        = 1'b1;
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = issue_cnt_r[SLOT_W-1:0];
          issue_cnt_nxt = issue_cnt_r + SLOT_CNT_W'(1);
        end
        if (free_here && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = cmp_idx_r;
        end
        if (hit) begin
          slot_nxt  = cmp_idx_r;
          alloc_nxt = 1'b0;
          if (req_kind_r == KIND_DELETE) begin
            slot_valid_nxt[cmp_idx_r] = 1'b0;
            res_status_nxt = ST_OK;
            state_nxt      = S_FINISH;
          end else begin
            len_re    = 1'b1;
            len_raddr = cmp_idx_r;
            state_nxt = S_LEN;
          end
        end else if (last) begin
          if (req_kind_r == KIND_WRITE && (free_found_r || free_here)) begin
            // New key takes the lowest free slot
            slot_nxt  = free_found_r ? free_idx_r : cmp_idx_r;
            alloc_nxt = 1'b1;
            len_re    = 1'b1;
            len_raddr = slot_nxt;
            state_nxt = S_LEN;
          end else begin
            res_status_nxt = (req_kind_r == KIND_WRITE) ? ST_FULL : ST_NOT_STORED;
            state_nxt      = S_FINISH;
          end
        end
      end

      S_LEN: begin
        if (req_kind_r == KIND_WRITE) begin
          // Update the length row (fresh row on allocation) and the bytes
          len_wrow = alloc_r ? '0 : len_rdata;
          len_wrow[fsel*LEN_W +: LEN_W] = keep_len;
          len_we   = 1'b1;
          bytes_we = 1'b1;
          if (alloc_r) begin
            key_we = 1'b1;
            slot_valid_nxt[slot_r] = 1'b1;
          end
          res_status_nxt = ST_OK;
          state_nxt      = S_FINISH;
        end else if (stored_len == '0) begin
          res_status_nxt = ST_NOT_STORED;
          state_nxt      = S_FINISH;
        end else begin
          stored_nxt = stored_len;
          bytes_re   = 1'b1;
          state_nxt  = S_BYTES;
        end
      end

      S_BYTES: begin
        res_rlen_nxt   = rlen;
        res_rdata_nxt  = bytes_rdata & low_bytes_mask(rlen);
        res_status_nxt = ST_OK;
        state_nxt      = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_cnt_r  <= '0;
      cmp_vld_r    <= 1'b0;
      cmp_idx_r    <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      slot_r       <= '0;
      alloc_r      <= 1'b0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_cnt_r  <= issue_cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      slot_r       <= slot_nxt;
      alloc_r      <= alloc_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind_r  <= in_kind;
      req_key_r   <= {in_key_high, in_key_low};
      req_fidx_r  <= in_field_index;
      req_wdata_r <= in_write_data;
      req_count_r <= in_byte_count;
    end
    stored_r     <= stored_nxt;
    res_status_r <= res_status_nxt;
    res_rdata_r  <= res_rdata_nxt;
    res_rlen_r   <= res_rlen_nxt;
    if (out_load) begin
      out_status_r      <= res_status_r;
      out_read_data_r   <= res_rdata_r;
      out_read_length_r <= res_rlen_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_read_data_r;
  assign out_read_length = out_read_length_r;

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted request did not start");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_length == '0 && out_read_data == '0)
    else $error("failed request returned data");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_read_length <= LEN_W'(FIELD_BYTES_MAX))
    else $error("read length above eight");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> issue_cnt_r <= SLOT_CNT_W'(RECORD_SLOTS))
    else $error("scan ran past the table");

endmodule

// ----- bench/keyed_record_field_store_test.sv -----
// Self-checking bench for keyed_record_field_store: random and directed
// read/write/delete traffic, a behavioral table model, and in-order result checks.
// Depends on krfs_pkg and the keyed_record_field_store RTL.
`timescale 1ns / 100ps

module keyed_record_field_store_test;
  import krfs_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;   // no operation behind this code
  localparam int KEY_POOL         = 40;        // more keys than slots, so the table fills
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT      = 2000;      // cycles with no transfer on either side
  localparam int DRAIN_CYCLES     = 80;
  localparam logic [127:0] KEY_ZERO = '0;
  localparam logic [127:0] KEY_ONES = '1;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [7:0]  field;
    logic [63:0] wdata;
    logic [7:0]  count;
  } field_request_t;

  typedef struct {
    krfs_status_t status;
    logic [63:0]  data;
    logic [3:0]   length;
  } field_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [63:0] in_key_high = '0;
  logic [63:0] in_key_low = '0;
  logic [7:0]  in_field_index = '0;
  logic [63:0] in_write_data = '0;
  logic [7:0]  in_byte_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_read_data;
  logic [3:0]  out_read_length;

  // Table model state
  logic         slot_used  [RECORD_SLOTS] = '{default: 1'b0};
  logic [127:0] slot_tag   [RECORD_SLOTS];
  int unsigned  stored_len [RECORD_SLOTS][FIELDS_PER_RECORD];
  logic [63:0]  stored_val [RECORD_SLOTS][FIELDS_PER_RECORD];

  field_result_t expected_results[$];
  logic [127:0]  key_pool[KEY_POOL];
  int mismatch_count = 0;
  int stalled_cycles = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  bit long_hold_req = 1'b0;

  keyed_record_field_store dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_key_high     (in_key_high),
    .in_key_low      (in_key_low),
    .in_field_index  (in_field_index),
    .in_write_data   (in_write_data),
    .in_byte_count   (in_byte_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_data   (out_read_data),
    .out_read_length (out_read_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Keeps the lowest n bytes of a word
  function automatic logic [63:0] keep_mask(input int unsigned n);
    return (n >= 8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // Applies one request to the table model and returns its result
  function automatic field_result_t predict_store(input field_request_t r);
    field_result_t res;
    int hit;
    int spare;
    int unsigned keep;
    res.status = ST_INVALID;
    res.data   = '0;
    res.length = '0;
    hit   = -1;
    spare = -1;
    // walk downward so both indexes end on the lowest match
    for (int s = RECORD_SLOTS - 1; s >= 0; s--) begin
      if (slot_used[s] && slot_tag[s] == {r.key_high, r.key_low}) hit = s;
      if (!slot_used[s]) spare = s;
    end
    case (r.kind)
      KIND_READ: begin
        if (hit < 0 || r.field >= FIELDS_PER_RECORD || stored_len[hit][r.field] == 0) begin
          res.status = ST_NOT_STORED;
        end else begin
          keep = (stored_len[hit][r.field] < r.count) ? stored_len[hit][r.field] : r.count;
          res.data   = stored_val[hit][r.field] & keep_mask(keep);
          res.length = 4'(keep);
          res.status = ST_OK;
        end
      end
      KIND_WRITE: begin
        if (r.count == 0 || r.field >= FIELDS_PER_RECORD) begin
          res.status = ST_INVALID;
        end else begin
          // new key: claim the lowest free slot with an empty record
          if (hit < 0 && spare >= 0) begin
            hit = spare;
            slot_used[hit] = 1'b1;
            slot_tag[hit]  = {r.key_high, r.key_low};
            for (int f = 0; f < FIELDS_PER_RECORD; f++) begin
              stored_len[hit][f] = 0;
              stored_val[hit][f] = '0;
            end
          end
          if (hit < 0) begin
            res.status = ST_FULL;
          end else begin
            keep = (r.count < FIELD_BYTES_MAX) ? r.count : FIELD_BYTES_MAX;
            stored_val[hit][r.field] = r.wdata & keep_mask(keep);
            stored_len[hit][r.field] = keep;
            res.status = ST_OK;
          end
        end
      end
      KIND_DELETE: begin
        if (hit < 0) begin
          res.status = ST_NOT_STORED;
        end else begin
          slot_used[hit] = 1'b0;
          res.status = ST_OK;
        end
      end
      default: res.status = ST_INVALID;
    endcase
    return res;
  endfunction

  function automatic field_request_t make_request(input logic [1:0] kind,
                                                  input logic [127:0] key,
                                                  input logic [7:0] field,
                                                  input logic [63:0] wdata,
                                                  input logic [7:0] count);
    field_request_t r;
    r.kind     = kind;
    r.key_high = key[127:64];
    r.key_low  = key[63:0];
    r.field    = field;
    r.wdata    = wdata;
    r.count    = count;
    return r;
  endfunction

  function automatic logic [127:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Offers one request, with an optional idle burst first, and waits for its transfer
  task automatic send_request(input field_request_t r);
    if ($urandom_range(1, 100) <= src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= r.kind;
    in_key_high    <= r.key_high;
    in_key_low     <= r.key_low;
    in_field_index <= r.field;
    in_write_data  <= r.wdata;
    in_byte_count  <= r.count;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  // One random request, mostly on pooled keys and in-range fields
  task automatic random_request(input int delete_pct);
    field_request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) r.kind = KIND_UNUSED;
    else if (pick < 2 + delete_pct) r.kind = KIND_DELETE;
    else if (pick < 2 + delete_pct + (98 - delete_pct) / 2) r.kind = KIND_WRITE;
    else r.kind = KIND_READ;
    {r.key_high, r.key_low} = ($urandom_range(0, 9) == 0) ? random_key()
                              : key_pool[$urandom_range(0, KEY_POOL - 1)];
    r.field = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
              : 8'($urandom_range(0, FIELDS_PER_RECORD - 1));
    r.wdata = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (r.kind == KIND_WRITE) begin
      if (pick < 5) r.count = 8'd0;
      else if (pick < 15) r.count = 8'($urandom_range(9, 255));
      else r.count = 8'($urandom_range(1, 8));
    end else begin
      r.count = (pick < 10) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 9));
    end
    send_request(r);
  endtask

  // Extremes and special cases, one request each
  task automatic test_directed_edges();
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    send_request(make_request(KIND_READ, KEY_ZERO, 8'd0, '0, 8'd8));
    send_request(make_request(KIND_DELETE, KEY_ZERO, 8'd0, '0, 8'd0));
    send_request(make_request(KIND_UNUSED, KEY_ONES, 8'd255, '1, 8'd255));
    send_request(make_request(KIND_WRITE, KEY_ONES, 8'd0, '1, 8'd0));
    send_request(make_request(KIND_WRITE, KEY_ONES, 8'(FIELDS_PER_RECORD), '1, 8'd4));
    send_request(make_request(KIND_WRITE, KEY_ONES, 8'd255, '1, 8'd8));
    send_request(make_request(KIND_WRITE, KEY_ONES, 8'd0, '1, 8'd8));
    // long value is cut to eight bytes
    send_request(make_request(KIND_WRITE, KEY_ONES, 8'(FIELDS_PER_RECORD - 1),
                              64'hFEDC_BA98_7654_3210, 8'd255));
    send_request(make_request(KIND_WRITE, KEY_ONES, 8'd3, 64'h0123_4567_89AB_CDEF, 8'd3));
    send_request(make_request(KIND_READ, KEY_ONES, 8'd0, '0, 8'd8));
    send_request(make_request(KIND_READ, KEY_ONES, 8'(FIELDS_PER_RECORD - 1), '0, 8'd255));
    send_request(make_request(KIND_READ, KEY_ONES, 8'd3, '0, 8'd0));
    send_request(make_request(KIND_READ, KEY_ONES, 8'd3, '0, 8'd2));
    send_request(make_request(KIND_READ, KEY_ONES, 8'd3, '0, 8'd8));
    send_request(make_request(KIND_READ, KEY_ONES, 8'd1, '0, 8'd8));
    send_request(make_request(KIND_READ, KEY_ONES, 8'd200, '0, 8'd8));
    // one key bit off must miss
    send_request(make_request(KIND_READ, KEY_ONES ^ 128'd1, 8'd0, '0, 8'd8));
    send_request(make_request(KIND_WRITE, KEY_ZERO, 8'd5, '0, 8'd1));
    send_request(make_request(KIND_READ, KEY_ZERO, 8'd5, '0, 8'd1));
    send_request(make_request(KIND_DELETE, KEY_ONES, 8'd0, '0, 8'd0));
    send_request(make_request(KIND_READ, KEY_ONES, 8'd0, '0, 8'd8));
    // reallocation must start with an empty record
    send_request(make_request(KIND_WRITE, KEY_ONES, 8'(FIELDS_PER_RECORD - 1), '1, 8'd9));
    send_request(make_request(KIND_READ, KEY_ONES, 8'd0, '0, 8'd8));
    send_request(make_request(KIND_READ, KEY_ONES, 8'(FIELDS_PER_RECORD - 1), '0, 8'd7));
    send_request(make_request(KIND_DELETE, KEY_ZERO, 8'd0, '0, 8'd0));
  endtask

  // Fill every slot, overflow, free one in the middle, then empty the table
  task automatic test_fill_table();
    logic [127:0] fresh [RECORD_SLOTS + 4];
    foreach (fresh[i]) fresh[i] = random_key();
    src_idle_pct  = 15;
    sink_idle_pct = 15;
    foreach (fresh[i])
      send_request(make_request(KIND_WRITE, fresh[i], 8'($urandom_range(0, FIELDS_PER_RECORD - 1)),
                                {$urandom, $urandom}, 8'($urandom_range(1, 12))));
    send_request(make_request(KIND_DELETE, fresh[5], 8'd0, '0, 8'd0));
    send_request(make_request(KIND_WRITE, fresh[RECORD_SLOTS + 2], 8'd0, {$urandom, $urandom},
                              8'd8));
    send_request(make_request(KIND_WRITE, fresh[RECORD_SLOTS + 3], 8'd0, {$urandom, $urandom},
                              8'd8));
    foreach (fresh[i])
      send_request(make_request(KIND_READ, fresh[i], 8'($urandom_range(0, FIELDS_PER_RECORD - 1)),
                                '0, 8'($urandom_range(0, 9))));
    foreach (fresh[i])
      send_request(make_request(KIND_DELETE, fresh[i], 8'd0, '0, 8'd0));
    send_request(make_request(KIND_DELETE, KEY_ONES, 8'd0, '0, 8'd0));
  endtask

  // Results held off for a long stretch while requests keep coming
  task automatic test_result_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    long_hold_req = 1'b1;
    repeat (12) random_request(10);
  endtask

  // Mixed traffic on a pool of keys, some of them one bit apart
  task automatic test_random_traffic(input int items, input int delete_pct);
    for (int i = 0; i < KEY_POOL; i++)
      key_pool[i] = (i >= KEY_POOL - 4) ? key_pool[i - (KEY_POOL - 4)] ^
                                          (128'd1 << $urandom_range(0, 127))
                                        : random_key();
    for (int n = 0; n < items; n++) begin
      // change the idle mix now and then, quiet stretches included
      if (n % 100 == 0) begin
        src_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 4);
        sink_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 4);
      end
      random_request(delete_pct);
    end
  endtask

  // Last stretch at full rate on both sides
  task automatic test_quiet_tail(input int items);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (items) random_request(10);
  endtask

  // Result receiver: ready runs, idle bursts, and one long hold on request
  initial begin : result_sink
    int hold;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        hold = LONG_HOLD_CYCLES;
      end else if ($urandom_range(1, 100) <= sink_idle_pct) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 10);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(1, 16);
      end
      repeat (hold) @(posedge clk);
    end
  end

  // Predict on every request transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_results.push_back(predict_store(make_request(in_kind, {in_key_high, in_key_low},
                                                             in_field_index, in_write_data,
                                                             in_byte_count)));
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    field_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, expected none, actual status %0d data %h length %0d",
                 $time, out_status, out_read_data, out_read_length);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status) begin
          mismatch_count++;
          $display("%0t ns: status mismatch, expected %0d, actual %0d",
                   $time, e.status, out_status);
        end
        if (out_read_data !== e.data) begin
          mismatch_count++;
          $display("%0t ns: read_data mismatch, expected %h, actual %h",
                   $time, e.data, out_read_data);
        end
        if (out_read_length !== e.length) begin
          mismatch_count++;
          $display("%0t ns: read_length mismatch, expected %0d, actual %0d",
                   $time, e.length, out_read_length);
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("%0t ns: watchdog, no transfer for %0d cycles, %0d results outstanding",
               $time, stalled_cycles, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_fill_table();
    test_result_backpressure();
    test_random_traffic(600, 5);
    test_random_traffic(640, 20);
    test_quiet_tail(60);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
